### rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the startup frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [8:0]  MAX_PAYLOAD = 9'd256;
  localparam logic [7:0]  MAGIC_BYTE  = 8'h3C;
  localparam logic [19:0] IDLE_MAX    = 20'hFFFFF;

  localparam logic [8:0]  MAX_LENGTH_RST   = 9'd256;
  localparam logic [19:0] IDLE_LIMIT_RST   = 20'd5000;
  localparam logic [19:0] FRAME_LIMIT_RST  = 20'd1000;
  localparam logic [7:0]  START_CODE_A_RST = 8'd1;
  localparam logic [7:0]  START_CODE_B_RST = 8'd22;

  typedef enum logic [1:0] {
    PH_MAGIC = 2'd0,
    PH_LEN0  = 2'd1,
    PH_LEN1  = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_HDR     = 3'd1,
    ST_BYTE    = 3'd2,
    ST_ACCEPT  = 3'd3,
    ST_REJECT  = 3'd4,
    ST_MAGIC   = 3'd5,
    ST_LEN     = 3'd6,
    ST_TIMEOUT = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    CFG_MAX_LENGTH   = 3'd0,
    CFG_IDLE_LIMIT   = 3'd1,
    CFG_FRAME_LIMIT  = 3'd2,
    CFG_START_CODE_A = 3'd3,
    CFG_START_CODE_B = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  payload_index;
    logic [7:0]  payload_byte;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

### rtl/core/startup_frame_deframer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// startup_frame_deframer_unit
// Parses '<' + 16-bit little-endian length + payload; reports per item.
// ----------------------------------------------------------------------------
// One item (a byte or a time tick) is taken per clock while s_axis_tready is high
// and gives exactly one registered result; the parse state update is a single
// registered step. A two-entry output stage (result register plus skid register)
// lets a new item in while a result waits, so throughput is one item per cycle
// whenever the output side is taking transfers. Configuration is written through
// the cfg port, which is always ready, and must only change while idle.
module startup_frame_deframer_unit
  import sfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [31:16] frame_length
  output logic [31:0]      m_axis_tdata,
  output logic [2:0]       m_axis_tuser,   // [2:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  logic [8:0]  max_length;
  logic [19:0] idle_limit;
  logic [19:0] frame_limit;
  logic [7:0]  start_code_a;
  logic [7:0]  start_code_b;

  phase_t      phase, phase_next;
  logic [15:0] length_value, length_value_next;
  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  first_payload, first_payload_next;
  logic [19:0] idle_ticks, idle_ticks_next;

  result_t res, out_res, skid_res;
  logic    out_valid, skid_valid;
  logic    s_accept;

  logic [19:0] ticks_inc;
  logic [19:0] limit;
  logic        timeout;
  logic [15:0] len_new;
  logic [8:0]  cap;
  logic        len_bad;
  logic [8:0]  pos_inc;
  logic        last_byte;
  logic [7:0]  cmd;
  logic [7:0]  b;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  assign ticks_inc = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 20'd1;
  assign limit     = (phase == PH_MAGIC) ? idle_limit : frame_limit;
  assign timeout   = ticks_inc > limit;
  assign len_new   = {b, length_value[7:0]};
  assign cap       = (max_length > MAX_PAYLOAD) ? MAX_PAYLOAD : max_length;
  assign len_bad   = (len_new == 16'd0) || (len_new > {7'd0, cap});
  assign pos_inc   = byte_position + 9'd1;
  assign last_byte = {7'd0, pos_inc} >= length_value;
  assign cmd       = (byte_position == 9'd0) ? b : first_payload;

  // next state
  always_comb begin
    phase_next         = phase;
    length_value_next  = length_value;
    byte_position_next = byte_position;
    first_payload_next = first_payload;
    idle_ticks_next    = 20'd0;
    if (s_axis_tuser == REQ_TICK) begin
      idle_ticks_next = ticks_inc;
      if (timeout) begin
        phase_next         = PH_MAGIC;
        length_value_next  = 16'd0;
        byte_position_next = 9'd0;
        idle_ticks_next    = 20'd0;
      end
    end else begin
      case (phase)
        PH_MAGIC: begin
          if (b == MAGIC_BYTE) phase_next = PH_LEN0;
          else begin
            length_value_next  = 16'd0;
            byte_position_next = 9'd0;
          end
        end
        PH_LEN0: begin
          length_value_next = {8'd0, b};
          phase_next        = PH_LEN1;
        end
        PH_LEN1: begin
          byte_position_next = 9'd0;
          if (len_bad) begin
            phase_next        = PH_MAGIC;
            length_value_next = 16'd0;
          end else begin
            length_value_next = len_new;
            phase_next        = PH_DATA;
          end
        end
        default: begin
          if (byte_position == 9'd0) first_payload_next = b;
          byte_position_next = pos_inc;
          if (last_byte) begin
            phase_next         = PH_MAGIC;
            length_value_next  = 16'd0;
            byte_position_next = 9'd0;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res.status        = ST_NONE;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.frame_length  = length_value;
    if (s_axis_tuser == REQ_TICK) begin
      if (timeout) res.status = ST_TIMEOUT;
    end else begin
      case (phase)
        PH_MAGIC: begin
          if (b == MAGIC_BYTE) res.status = ST_HDR;
          else begin
            res.status       = ST_MAGIC;
            res.frame_length = 16'd0;
          end
        end
        PH_LEN0: begin
          res.status       = ST_HDR;
          res.frame_length = {8'd0, b};
        end
        PH_LEN1: begin
          res.status       = len_bad ? ST_LEN : ST_HDR;
          res.frame_length = len_new;
        end
        default: begin
          res.payload_byte  = b;
          res.payload_index = byte_position[7:0];
          if (!last_byte) res.status = ST_BYTE;
          else if (cmd == start_code_a || cmd == start_code_b) res.status = ST_ACCEPT;
          else res.status = ST_REJECT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length   <= MAX_LENGTH_RST;
      idle_limit   <= IDLE_LIMIT_RST;
      frame_limit  <= FRAME_LIMIT_RST;
      start_code_a <= START_CODE_A_RST;
      start_code_b <= START_CODE_B_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_LENGTH:   max_length   <= cfg_data[8:0];
        CFG_IDLE_LIMIT:   idle_limit   <= cfg_data;
        CFG_FRAME_LIMIT:  frame_limit  <= cfg_data;
        CFG_START_CODE_A: start_code_a <= cfg_data[7:0];
        CFG_START_CODE_B: start_code_b <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      length_value  <= 16'd0;
      byte_position <= 9'd0;
      first_payload <= 8'd0;
      idle_ticks    <= 20'd0;
    end else if (s_accept) begin
      phase         <= phase_next;
      length_value  <= length_value_next;
      byte_position <= byte_position_next;
      first_payload <= first_payload_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || s_accept;
      skid_valid <= 1'b0;
    end else if (s_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (s_accept) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.frame_length, out_res.payload_index, out_res.payload_byte};
  assign m_axis_tuser  = out_res.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while the output register is empty");

  a_pos_outside_frame: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_DATA) |-> (byte_position == 9'd0))
    else $error("byte position not cleared outside payload");

  a_len_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (length_value != 16'd0 && length_value <= {7'd0, MAX_PAYLOAD}))
    else $error("payload phase with out-of-range length");

  a_pos_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> ({7'd0, byte_position} < length_value))
    else $error("byte position reached frame length without ending frame");

endmodule
`default_nettype wire
